@@ design/hkt_pkg.sv @@
// Shared types and constants for the held key tracking table.
// Used by hkt_cell, hkt_chain and held_key_tracking_table_top; no dependencies.
`timescale 1ns / 1ps

package hkt_pkg;

  // Default table depth
  localparam int MaxHeldDef = 8;

  // Stream payload widths, in bits
  localparam int InDataW  = 48;
  localparam int OutDataW = 64;

  // One held key
  typedef struct packed {
    logic [15:0] down;
    logic [15:0] code;
    logic [7:0]  col;
    logic [7:0]  row;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic        hit;
    logic [15:0] up;
    logic [15:0] down;
    logic [15:0] code;
    logic [7:0]  col;
    logic [7:0]  row;
  } result_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

endpackage

@@ design/hkt_cell.sv @@
// One slot of the held key chain: holds one entry, takes its upper neighbor on a shift
// or the broadcast entry when it is the addressed slot. Depends on hkt_pkg.
`timescale 1ns / 1ps

module hkt_cell #(
  parameter int IdxW  = 3,
  parameter int Index = 0
) (
  input  logic               clk_i,
  input  hkt_pkg::chain_ctl_t ctl_i,
  input  logic [IdxW-1:0]    idx_i,
  input  hkt_pkg::entry_t    load_i,
  input  hkt_pkg::entry_t    next_i,
  output hkt_pkg::entry_t    q_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  hkt_pkg::entry_t entry_q;

  // Load wins over shift: the tail slot takes the recirculated head
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && (idx_i == MyIdx)) begin
      entry_q <= load_i;
    end else if (ctl_i.shift) begin
      entry_q <= next_i;
    end
  end

  assign q_o = entry_q;

endmodule

@@ design/hkt_chain.sv @@
// Row of hkt_cell slots; slot 0 holds the oldest held key and is the head of the chain.
// Depends on hkt_pkg and hkt_cell.
`timescale 1ns / 1ps

module hkt_chain #(
  parameter int MaxHeld = hkt_pkg::MaxHeldDef,
  parameter int IdxW    = (MaxHeld > 1) ? $clog2(MaxHeld) : 1
) (
  input  logic                clk_i,
  input  hkt_pkg::chain_ctl_t ctl_i,
  input  logic [IdxW-1:0]     idx_i,
  input  hkt_pkg::entry_t     load_i,
  output hkt_pkg::entry_t     head_o
);

  hkt_pkg::entry_t slot [MaxHeld];

  for (genvar g = 0; g < MaxHeld; g++) begin : g_cell
    hkt_pkg::entry_t next;

    // Each slot takes its upper neighbor; the top slot holds its own value
    if (g == MaxHeld - 1) begin : g_top
      assign next = slot[g];
    end else begin : g_mid
      assign next = slot[g+1];
    end

    hkt_cell #(
      .IdxW  (IdxW),
      .Index (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .idx_i  (idx_i),
      .load_i (load_i),
      .next_i (next),
      .q_o    (slot[g])
    );
  end

  assign head_o = slot[0];

endmodule

@@ design/held_key_tracking_table_top.sv @@
// Held key tracking table: sequencer, result registers and the chain of key slots.
// Depends on hkt_pkg and hkt_chain.
//
// Usage:
//   Input stream s_axis: one key event per beat. tuser carries the pressed flag,
//   tdata the row, column, keycode and event time. Output stream m_axis: one result
//   per event. tuser carries the hit flag, tdata the entry and its time stamps.
//   A press appends to the tail slot in the accept cycle if a slot is free. A
//   release circulates the table through slot 0 once, one held entry per cycle,
//   comparing row and column; the first match is dropped from the circulation,
//   which closes the gap. A press, or a release on an empty table, goes straight
//   to the emit state; a release otherwise scans count entries first (count =
//   keys held, up to MAX_HELD). One event is in work at a time, so the next
//   event is taken only once the result has moved on to the output register.
//   The output register lets the next event be taken while a result waits.
//   Reset empties the table (count to zero) and clears the output valid.
//   When the receiver stalls, the finished result waits in the sequencer until the
//   output register frees; s_axis_tready stays low meanwhile.
`timescale 1ns / 1ps

module held_key_tracking_table_top #(
  parameter int MAX_HELD = hkt_pkg::MaxHeldDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [7:0] key_row, [15:8] key_col, [31:16] key_code, [47:32] event_time
  input  logic [hkt_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] pressed
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] out_row, [15:8] out_col, [31:16] out_keycode, [47:32] down_stamp,
  // [63:48] up_stamp
  output logic [hkt_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] hit
  output logic                         m_axis_tuser
);

  localparam int CntW = $clog2(MAX_HELD + 1);
  localparam int IdxW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_HELD);
  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntTwo = CntW'(2);

  hkt_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     step_q, step_d;
  logic                dropped_q, dropped_d;
  logic [7:0]          key_row_q, key_row_d;
  logic [7:0]          key_col_q, key_col_d;
  logic [15:0]         up_q, up_d;
  hkt_pkg::result_t    res_q, res_d;
  logic                out_valid_q;
  hkt_pkg::result_t    out_res_q;

  hkt_pkg::entry_t     in_entry;
  hkt_pkg::entry_t     head;
  hkt_pkg::entry_t     load_entry;
  hkt_pkg::chain_ctl_t ctl;
  logic [IdxW-1:0]     load_idx;
  logic [CntW-1:0]     push_pos;
  logic                in_acc;
  logic                match;
  logic                last_step;
  logic                out_load;

  // Unpack the input beat
  assign in_entry.row  = s_axis_tdata[7:0];
  assign in_entry.col  = s_axis_tdata[15:8];
  assign in_entry.code = s_axis_tdata[31:16];
  assign in_entry.down = s_axis_tdata[47:32];

  assign s_axis_tready = (state_q == hkt_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Compare the head slot against the released key; only the first match counts
  assign match     = !dropped_q && (head.row == key_row_q) && (head.col == key_col_q);
  assign last_step = (step_q == (count_q - CntOne));
  assign push_pos  = dropped_q ? (count_q - CntTwo) : (count_q - CntOne);
  assign out_load  = (state_q == hkt_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);

  // Sequencer: next state and chain controls
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    step_d     = step_q;
    dropped_d  = dropped_q;
    key_row_d  = key_row_q;
    key_col_d  = key_col_q;
    up_d       = up_q;
    res_d      = res_q;
    ctl        = '0;
    load_idx   = count_q[IdxW-1:0];
    load_entry = in_entry;

    unique case (state_q)
      hkt_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          state_d = hkt_pkg::ST_EMIT;
          if (s_axis_tuser) begin
            // Press: append at the tail if a slot is free
            if (count_q < CntMax) begin
              ctl.load   = 1'b1;
              count_d    = count_q + CntOne;
              res_d.hit  = 1'b1;
              res_d.row  = in_entry.row;
              res_d.col  = in_entry.col;
              res_d.code = in_entry.code;
              res_d.down = in_entry.down;
            end
          end else begin
            // Release: circulate the table once unless it is empty
            key_row_d = in_entry.row;
            key_col_d = in_entry.col;
            up_d      = in_entry.down;
            step_d    = '0;
            dropped_d = 1'b0;
            if (count_q != '0) begin
              state_d = hkt_pkg::ST_SCAN;
            end
          end
        end
      end
      hkt_pkg::ST_SCAN: begin
        // Pop the head, push it back at the tail unless it is the match
        ctl.shift  = 1'b1;
        ctl.load   = !match;
        load_idx   = push_pos[IdxW-1:0];
        load_entry = head;
        step_d     = step_q + CntOne;
        if (match) begin
          dropped_d  = 1'b1;
          res_d.hit  = 1'b1;
          res_d.row  = head.row;
          res_d.col  = head.col;
          res_d.code = head.code;
          res_d.down = head.down;
          res_d.up   = up_q;
        end
        if (last_step) begin
          state_d = hkt_pkg::ST_EMIT;
          if (match || dropped_q) begin
            count_d = count_q - CntOne;
          end
        end
      end
      hkt_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = hkt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hkt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hkt_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    dropped_q <= dropped_d;
    key_row_q <= key_row_d;
    key_col_q <= key_col_d;
    up_q      <= up_d;
    res_q     <= res_d;
    if (out_load) begin
      out_res_q <= res_q;
    end
  end

  hkt_chain #(
    .MaxHeld (MAX_HELD),
    .IdxW    (IdxW)
  ) u_chain (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .idx_i  (load_idx),
    .load_i (load_entry),
    .head_o (head)
  );

  // Pack the output beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.hit;
  assign m_axis_tdata  = {out_res_q.up, out_res_q.down, out_res_q.code,
                          out_res_q.col, out_res_q.row};

  // The table never holds more keys than it has slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("held count exceeds table depth");

  // The circulation never runs past the held entries
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hkt_pkg::ST_SCAN) |-> (step_q < count_q))
    else $error("scan step beyond held count");

  // A press on a full table leaves the count unchanged
  a_full_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser && (count_q == CntMax)) |=> (count_q == CntMax))
    else $error("press on full table changed the count");

  // A release can only shrink the table by one
  a_release_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == hkt_pkg::ST_SCAN) && last_step) |=>
      ((count_q == $past(count_q)) || (count_q == $past(count_q) - CntOne)))
    else $error("release changed the count by more than one");

endmodule
